>>> rtl/msst_pkg.sv
// ----------------------------------------------------------------------------
// msst_pkg
// Shared types and constants of the timer slot table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msst_pkg;

  // table size and derived widths
  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(NUM_SLOTS + 1);

  localparam logic [15:0] ID_FIRST = 16'd1;
  localparam logic [15:0] ID_MAX   = 16'hFFFF;

  // opcodes
  localparam logic [2:0] OP_CHECK   = 3'd0;
  localparam logic [2:0] OP_CREATE  = 3'd1;
  localparam logic [2:0] OP_DELETE  = 3'd2;
  localparam logic [2:0] OP_RESTART = 3'd3;
  localparam logic [2:0] OP_ENABLE  = 3'd4;
  localparam logic [2:0] OP_DISABLE = 3'd5;
  localparam logic [2:0] OP_TOGGLE  = 3'd6;
  localparam logic [2:0] OP_QUERY   = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SLOT   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] now_ms;
    logic [30:0] delay_ms;
    logic [14:0] run_limit;
    logic [15:0] target_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_id;
    logic        fired;
    logic        removed;
    logic        enabled_flag;
    logic [4:0]  active_count;
    logic        last;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             scan;
    logic             apply;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] emit_idx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } stat_t;

endpackage

>>> rtl/msst_req_if.sv
// ----------------------------------------------------------------------------
// msst_req_if
// Request channel: valid, ready and one opcode request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface msst_req_if;
  logic          valid;
  logic          ready;
  msst_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/msst_rsp_if.sv
// ----------------------------------------------------------------------------
// msst_rsp_if
// Response channel: valid, ready and one result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface msst_rsp_if;
  logic          valid;
  logic          ready;
  msst_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/multi_slot_software_timer_table.sv
// ----------------------------------------------------------------------------
// multi_slot_software_timer_table
// Timer slot table driven by opcode requests, one request at a time.
// Steps: accept, a scan of every slot, one apply step, then results.
// A new request is taken only after all results of the last one are out;
// the sequential walk of the slot table sets the pace.
// Reset: all slots free, next identifier one, no request in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_slot_software_timer_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  msst_req_if.sink   req_i,
  msst_rsp_if.source rsp_o
);

  msst_pkg::cmd_t  cmd;
  msst_pkg::stat_t stat;

  // controller
  msst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath
  msst_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i.data),
    .rsp_o  (rsp_o.data),
    .stat_o (stat)
  );

  // checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !req_i.ready)
    else $error("request taken while results pending");

  a_scan_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !rsp_o.valid)
    else $error("result before slot scan");

  a_fire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.data.fired) |-> (rsp_o.data.status == msst_pkg::ST_OK))
    else $error("fired result with error status");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.data.active_count <= 5'(msst_pkg::NUM_SLOTS)))
    else $error("active count out of range");

endmodule

>>> rtl/msst_datapath.sv
// ----------------------------------------------------------------------------
// msst_datapath
// Slot storage, per-slot scan logic, opcode apply and result formatting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msst_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  msst_pkg::cmd_t cmd_i,
  input  msst_pkg::req_t req_i,
  output msst_pkg::rsp_t rsp_o,
  output msst_pkg::stat_t stat_o
);

  localparam int unsigned N     = msst_pkg::NUM_SLOTS;
  localparam int unsigned IDX_W = msst_pkg::IDX_W;
  localparam int unsigned CNT_W = msst_pkg::CNT_W;

  // slot state
  logic [N-1:0]  used_q, enabled_q;
  logic [30:0]   period_q    [N];
  logic [31:0]   last_time_q [N];
  logic [14:0]   run_limit_q [N];
  logic [14:0]   run_count_q [N];
  logic [15:0]   ident_q     [N];
  logic [15:0]   next_ident_q;
  logic [CNT_W-1:0] used_count_q;

  // request and scan bookkeeping
  msst_pkg::req_t   req_q;
  logic             found_q;
  logic [IDX_W-1:0] sel_q;
  logic [CNT_W-1:0] nres_q;
  logic [15:0]      res_id_q  [N];
  logic [N-1:0]     res_rem_q;

  // slot under scan
  logic        rd_used, rd_en, expired, lim_zero, can_run, fire, del;
  logic        is_check, hit;
  logic [31:0] elapsed;
  logic [14:0] cnt_inc;

  always_comb begin
    rd_used  = used_q[cmd_i.idx];
    rd_en    = enabled_q[cmd_i.idx];
    elapsed  = req_q.now_ms - last_time_q[cmd_i.idx];
    expired  = rd_used && (elapsed >= {1'b0, period_q[cmd_i.idx]});
    lim_zero = (run_limit_q[cmd_i.idx] == 15'd0);
    can_run  = (run_count_q[cmd_i.idx] < run_limit_q[cmd_i.idx]);
    cnt_inc  = run_count_q[cmd_i.idx] + 15'd1;
    fire     = expired && rd_en && (lim_zero || can_run);
    del      = expired && rd_en && !lim_zero && can_run &&
               (cnt_inc >= run_limit_q[cmd_i.idx]);
    is_check = (req_q.opcode == msst_pkg::OP_CHECK);
    if (req_q.opcode == msst_pkg::OP_CREATE) begin
      hit = !found_q && !rd_used;
    end else begin
      hit = !found_q && (req_q.target_id != 16'd0) && rd_used &&
            (ident_q[cmd_i.idx] == req_q.target_id);
    end
  end

  // control state and slot fields with a defined reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q       <= '0;
      enabled_q    <= '0;
      for (int k = 0; k < N; k++) begin
        period_q[k]    <= '0;
        last_time_q[k] <= '0;
        run_count_q[k] <= '0;
        ident_q[k]     <= '0;
      end
      next_ident_q <= msst_pkg::ID_FIRST;
      used_count_q <= '0;
      found_q      <= 1'b0;
      nres_q       <= '0;
    end else if (cmd_i.load) begin
      found_q <= 1'b0;
      nres_q  <= '0;
    end else if (cmd_i.scan) begin
      if (is_check) begin
        // periodic check of one slot
        if (expired) begin
          last_time_q[cmd_i.idx] <= last_time_q[cmd_i.idx] + {1'b0, period_q[cmd_i.idx]};
          if (rd_en && !lim_zero && can_run && !del) begin
            run_count_q[cmd_i.idx] <= cnt_inc;
          end
          if (fire) begin
            nres_q <= nres_q + CNT_W'(1);
          end
          if (del) begin
            used_q[cmd_i.idx]      <= 1'b0;
            enabled_q[cmd_i.idx]   <= 1'b0;
            period_q[cmd_i.idx]    <= '0;
            run_count_q[cmd_i.idx] <= '0;
            ident_q[cmd_i.idx]     <= '0;
            used_count_q           <= used_count_q - CNT_W'(1);
          end
        end
      end else if (hit) begin
        found_q <= 1'b1;
      end
    end else if (cmd_i.apply && !is_check && found_q) begin
      // single-slot operations
      case (req_q.opcode)
        msst_pkg::OP_CREATE: begin
          used_q[sel_q]      <= 1'b1;
          enabled_q[sel_q]   <= 1'b1;
          period_q[sel_q]    <= req_q.delay_ms;
          last_time_q[sel_q] <= req_q.now_ms;
          run_count_q[sel_q] <= '0;
          ident_q[sel_q]     <= next_ident_q;
          next_ident_q       <= (next_ident_q == msst_pkg::ID_MAX) ?
                                msst_pkg::ID_FIRST : next_ident_q + 16'd1;
          used_count_q       <= used_count_q + CNT_W'(1);
        end
        msst_pkg::OP_DELETE: begin
          used_q[sel_q]      <= 1'b0;
          enabled_q[sel_q]   <= 1'b0;
          period_q[sel_q]    <= '0;
          run_count_q[sel_q] <= '0;
          ident_q[sel_q]     <= '0;
          used_count_q       <= used_count_q - CNT_W'(1);
        end
        msst_pkg::OP_RESTART: last_time_q[sel_q] <= req_q.now_ms;
        msst_pkg::OP_ENABLE:  enabled_q[sel_q]   <= 1'b1;
        msst_pkg::OP_DISABLE: enabled_q[sel_q]   <= 1'b0;
        msst_pkg::OP_TOGGLE:  enabled_q[sel_q]   <= !enabled_q[sel_q];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.scan && is_check && fire) begin
      res_id_q[nres_q[IDX_W-1:0]]  <= ident_q[cmd_i.idx];
      res_rem_q[nres_q[IDX_W-1:0]] <= del;
    end
    if (cmd_i.scan && !is_check && hit) begin
      sel_q <= cmd_i.idx;
    end
    if (cmd_i.apply && found_q && (req_q.opcode == msst_pkg::OP_CREATE)) begin
      run_limit_q[sel_q] <= req_q.run_limit;
    end
  end

  // result formatting
  logic emit_last;

  always_comb begin
    emit_last = (nres_q == '0) ||
                ({{(CNT_W - IDX_W){1'b0}}, cmd_i.emit_idx} == nres_q - CNT_W'(1));
    rsp_o.active_count = 5'(used_count_q);
    rsp_o.fired        = 1'b0;
    rsp_o.removed      = 1'b0;
    rsp_o.last         = 1'b1;
    if (is_check) begin
      rsp_o.status       = msst_pkg::ST_OK;
      rsp_o.result_id    = '0;
      rsp_o.enabled_flag = 1'b0;
      rsp_o.last         = emit_last;
      if (nres_q != '0) begin
        rsp_o.result_id    = res_id_q[cmd_i.emit_idx];
        rsp_o.fired        = 1'b1;
        rsp_o.removed      = res_rem_q[cmd_i.emit_idx];
        rsp_o.enabled_flag = !res_rem_q[cmd_i.emit_idx];
      end
    end else if (req_q.opcode == msst_pkg::OP_CREATE) begin
      rsp_o.status       = found_q ? msst_pkg::ST_OK : msst_pkg::ST_NO_SLOT;
      rsp_o.result_id    = found_q ? ident_q[sel_q] : 16'd0;
      rsp_o.enabled_flag = found_q && enabled_q[sel_q];
    end else begin
      rsp_o.status       = found_q ? msst_pkg::ST_OK : msst_pkg::ST_NOT_FOUND;
      rsp_o.result_id    = req_q.target_id;
      rsp_o.enabled_flag = found_q && enabled_q[sel_q];
    end
    stat_o.last = rsp_o.last;
  end

endmodule

>>> rtl/msst_ctrl.sv
// ----------------------------------------------------------------------------
// msst_ctrl
// Sequencer: accept, slot scan, apply, result emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msst_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  input  msst_pkg::stat_t stat_i,
  output msst_pkg::cmd_t  cmd_o
);

  localparam int unsigned IDX_W = msst_pkg::IDX_W;
  localparam logic [IDX_W-1:0] IDX_END = IDX_W'(msst_pkg::NUM_SLOTS - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_EMIT} state_e;

  state_e           state_q;
  logic [IDX_W-1:0] idx_q, emit_q;

  // command decode
  always_comb begin
    req_ready_o    = (state_q == S_IDLE);
    rsp_valid_o    = (state_q == S_EMIT);
    cmd_o.load     = req_ready_o && req_valid_i;
    cmd_o.scan     = (state_q == S_SCAN);
    cmd_o.apply    = (state_q == S_APPLY);
    cmd_o.idx      = idx_q;
    cmd_o.emit_idx = emit_q;
  end

  // state machine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      emit_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            state_q <= S_SCAN;
            idx_q   <= '0;
          end
        end
        S_SCAN: begin
          idx_q <= idx_q + IDX_W'(1);
          if (idx_q == IDX_END) begin
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          state_q <= S_EMIT;
          emit_q  <= '0;
        end
        S_EMIT: begin
          if (rsp_ready_i) begin
            if (stat_i.last) begin
              state_q <= S_IDLE;
            end else begin
              emit_q <= emit_q + IDX_W'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> verif/tb_multi_slot_software_timer_table.sv
// ----------------------------------------------------------------------------
// tb_multi_slot_software_timer_table
// Self-checking bench for the timer slot table. A scoreboard class keeps its
// own copy of the slot table, predicts the results of every accepted request
// and checks each response in order. Directed requests cover full table, id
// zero, unknown ids, every opcode and time wrap; random traffic follows,
// with random idling on both sides and a long response hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class timer_scoreboard;

  bit          used [msst_pkg::NUM_SLOTS];
  bit          en   [msst_pkg::NUM_SLOTS];
  bit [30:0]   period [msst_pkg::NUM_SLOTS];
  bit [31:0]   start_t [msst_pkg::NUM_SLOTS];
  bit [14:0]   limit [msst_pkg::NUM_SLOTS];
  bit [14:0]   runs [msst_pkg::NUM_SLOTS];
  bit [15:0]   ident [msst_pkg::NUM_SLOTS];
  bit [15:0]   next_id;
  int unsigned n_used;
  msst_pkg::rsp_t expected_q [$];
  int          errors;
  int          mismatches;

  function new();
    next_id = msst_pkg::ID_FIRST;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void add_rsp(logic [1:0] st, logic [15:0] id, bit f, bit r, bit e, bit l);
    msst_pkg::rsp_t x;
    x.status = st;
    x.result_id = id;
    x.fired = f;
    x.removed = r;
    x.enabled_flag = e;
    x.active_count = n_used[4:0];
    x.last = l;
    expected_q.push_back(x);
  endfunction

  function void free_slot(int i);
    if (used[i] && n_used > 0) n_used--;
    used[i] = 0;
    en[i] = 0;
    period[i] = '0;
    runs[i] = '0;
    ident[i] = '0;
  endfunction

  // pick the id of a random live timer, or a random one if none
  function logic [15:0] some_id();
    int k;
    k = $urandom_range(msst_pkg::NUM_SLOTS - 1);
    for (int j = 0; j < msst_pkg::NUM_SLOTS; j++)
      if (used[(k + j) % msst_pkg::NUM_SLOTS]) return ident[(k + j) % msst_pkg::NUM_SLOTS];
    return 16'($urandom);
  endfunction

  // predict the responses of one accepted request
  function void note_request(msst_pkg::req_t q);
    logic [15:0] ids [$];
    bit          rem [$];
    bit [31:0]   elapsed;
    bit          fire, del;
    int          s;
    case (q.opcode)
      msst_pkg::OP_CHECK: begin
        for (int i = 0; i < msst_pkg::NUM_SLOTS; i++) begin
          if (!used[i]) continue;
          elapsed = q.now_ms - start_t[i];
          if (elapsed < {1'b0, period[i]}) continue;
          start_t[i] += {1'b0, period[i]};
          if (!en[i]) continue;
          fire = 0;
          del = 0;
          if (limit[i] == 0) fire = 1;
          else if (runs[i] < limit[i]) begin
            fire = 1;
            runs[i] = runs[i] + 1;
            if (runs[i] >= limit[i]) del = 1;
          end
          if (fire) begin
            ids.push_back(ident[i]);
            rem.push_back(del);
            if (del) free_slot(i);
          end
        end
        if (ids.size() == 0) add_rsp(msst_pkg::ST_OK, '0, 0, 0, 0, 1);
        for (int k = 0; k < ids.size(); k++)
          add_rsp(msst_pkg::ST_OK, ids[k], 1, rem[k], !rem[k], k == ids.size() - 1);
      end
      msst_pkg::OP_CREATE: begin
        s = -1;
        for (int i = 0; i < msst_pkg::NUM_SLOTS; i++)
          if (!used[i]) begin
            s = i;
            break;
          end
        if (s < 0) add_rsp(msst_pkg::ST_NO_SLOT, '0, 0, 0, 0, 1);
        else begin
          used[s] = 1;
          en[s] = 1;
          period[s] = q.delay_ms;
          limit[s] = q.run_limit;
          runs[s] = '0;
          start_t[s] = q.now_ms;
          ident[s] = next_id;
          n_used++;
          add_rsp(msst_pkg::ST_OK, next_id, 0, 0, 1, 1);
          next_id = (next_id == msst_pkg::ID_MAX) ? msst_pkg::ID_FIRST : next_id + 16'd1;
        end
      end
      default: begin
        s = -1;
        if (q.target_id != 0)
          for (int i = 0; i < msst_pkg::NUM_SLOTS; i++)
            if (used[i] && ident[i] == q.target_id) begin
              s = i;
              break;
            end
        if (s < 0) add_rsp(msst_pkg::ST_NOT_FOUND, q.target_id, 0, 0, 0, 1);
        else begin
          case (q.opcode)
            msst_pkg::OP_DELETE:  free_slot(s);
            msst_pkg::OP_RESTART: start_t[s] = q.now_ms;
            msst_pkg::OP_ENABLE:  en[s] = 1;
            msst_pkg::OP_DISABLE: en[s] = 0;
            msst_pkg::OP_TOGGLE:  en[s] = !en[s];
            default: ;
          endcase
          add_rsp(msst_pkg::ST_OK, q.target_id, 0, 0, en[s], 1);
        end
      end
    endcase
  endfunction

  // compare one response against the oldest prediction
  function void check_result(msst_pkg::rsp_t a);
    msst_pkg::rsp_t e;
    bit   bad;
    if (expected_q.size() == 0) begin
      errors++;
      mismatches++;
      if (mismatches <= 10) $display("unexpected response %p", a);
      return;
    end
    e = expected_q.pop_front();
    bad = (a.status !== e.status) || (a.result_id !== e.result_id) ||
          (a.fired !== e.fired) || (a.removed !== e.removed) ||
          (a.enabled_flag !== e.enabled_flag) ||
          (a.active_count !== e.active_count) || (a.last !== e.last);
    if (bad) begin
      errors++;
      mismatches++;
      if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, a);
    end
  endfunction
endclass

module tb_multi_slot_software_timer_table;

  logic clk;
  logic rst_n;
  msst_req_if req_if ();
  msst_rsp_if rsp_if ();

  timer_scoreboard sb;
  bit          calm;
  bit          hold_go;
  int          hold_left;
  logic [31:0] now_t;

  multi_slot_software_timer_table DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // response side: random stalls plus one long hold-off
  initial begin
    rsp_if.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (hold_go) begin
        hold_go = 0;
        hold_left = 300;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= calm || ($urandom_range(99) >= 23);
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
  end

  task automatic send(msst_pkg::req_t r);
    int gap;
    if (!calm && $urandom_range(99) < 23) begin
      gap = $urandom_range(1, 4);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic msst_pkg::req_t make_req(logic [2:0] op, logic [31:0] t,
                                              logic [30:0] d, logic [14:0] lim,
                                              logic [15:0] id);
    msst_pkg::req_t r;
    r.opcode = op;
    r.now_ms = t;
    r.delay_ms = d;
    r.run_limit = lim;
    r.target_id = id;
    return r;
  endfunction

  function automatic msst_pkg::req_t random_req();
    logic [2:0]  op;
    logic [30:0] d;
    logic [14:0] lim;
    logic [15:0] id;
    int          p;
    p = $urandom_range(99);
    if (p < 35) op = msst_pkg::OP_CHECK;
    else if (p < 57) op = msst_pkg::OP_CREATE;
    else op = 3'($urandom_range(msst_pkg::OP_DELETE, msst_pkg::OP_QUERY));
    if ($urandom_range(19) == 0) now_t = $urandom;
    else now_t += $urandom_range(0, 6);
    d = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 25));
    lim = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 4));
    p = $urandom_range(9);
    if (p < 7) id = sb.some_id();
    else if (p < 8) id = '0;
    else id = 16'($urandom);
    return make_req(op, now_t, d, lim, id);
  endfunction

  initial begin
    sb = new();
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    calm = 0;
    hold_go = 0;
    now_t = 32'd1000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fill the table, edge ids, each opcode, wrap of time
    for (int i = 0; i < msst_pkg::NUM_SLOTS; i++)
      send(make_req(msst_pkg::OP_CREATE, now_t, (i == 15) ? 31'h7FFF_FFFF : 31'(i),
                    (i % 4 == 0) ? 15'd0 : (i % 4 == 1) ? 15'd1 :
                    (i % 4 == 2) ? 15'h7FFF : 15'd2, '0));
    send(make_req(msst_pkg::OP_CREATE, now_t, 31'd5, 15'd1, '0));
    send(make_req(msst_pkg::OP_QUERY, now_t, '0, '0, 16'd0));
    send(make_req(msst_pkg::OP_DELETE, now_t, '0, '0, 16'hFFFF));
    send(make_req(msst_pkg::OP_DISABLE, now_t, '0, '0, 16'd3));
    send(make_req(msst_pkg::OP_TOGGLE, now_t, '0, '0, 16'd4));
    send(make_req(msst_pkg::OP_TOGGLE, now_t, '0, '0, 16'd4));
    send(make_req(msst_pkg::OP_ENABLE, now_t, '0, '0, 16'd3));
    send(make_req(msst_pkg::OP_DISABLE, now_t, '0, '0, 16'd6));
    send(make_req(msst_pkg::OP_RESTART, now_t + 2, '0, '0, 16'd7));
    send(make_req(msst_pkg::OP_CHECK, now_t + 3, '0, '0, '0));
    send(make_req(msst_pkg::OP_CHECK, now_t + 12, '0, '0, '0));
    send(make_req(msst_pkg::OP_DELETE, now_t, '0, '0, 16'd8));
    send(make_req(msst_pkg::OP_QUERY, now_t, '0, '0, 16'd16));
    send(make_req(msst_pkg::OP_CHECK, 32'hFFFF_FFFF, '0, '0, '0));
    send(make_req(msst_pkg::OP_CHECK, 32'd0, '0, '0, '0));
    now_t = 32'hFFFF_FFF0;
    drain();

    // random traffic
    for (int n = 0; n < 400; n++) begin
      calm = (n >= 60 && n < 120);
      if (n == 150) hold_go = 1;
      if (n == 250) drain();
      send(random_req());
    end
    calm = 0;
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
